// ----- src/sorted_table_insert_delete_core_defines.svh -----
// Assertion macros for the sorted table core.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef SORTED_TABLE_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_TABLE_INSERT_DELETE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STID_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted table core: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define STID_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted table core: next-cycle check failed");

`endif

// ----- src/stid_pkg.sv -----
// Shared types and codes for the sorted table core.
// Used by the controller, the datapath and the top level; depends on nothing.
package stid_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic rd;
        logic cmp;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic is_insert;
        logic full;
        logic at_end;
    } t_dp_status;

endpackage

// ----- src/stid_datapath.sv -----
// Datapath of the sorted table core: entry memory, scan index, carry and result register.
// Depends on stid_pkg; driven by stid_controller.
module stid_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stid_pkg::t_dp_cmd     i_cmd,
    input  stid_pkg::t_in_item    i_in,
    output stid_pkg::t_dp_status  o_status,
    output stid_pkg::t_out_item   o_out
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [31:0]        r_mem [TABLE_DEPTH];
    logic [31:0]        r_rd_data;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_idx;
    logic [IW-1:0]      r_pos;
    logic               r_found;
    logic               r_op;
    logic signed [31:0] r_value;
    logic [31:0]        r_carry;
    stid_pkg::t_out_item r_out;
    stid_pkg::t_out_item n_out;

    logic          w_full;
    logic          w_insert_adv;
    logic          w_en;
    logic [IW-1:0] w_addr;
    logic [31:0]   w_data;
    logic [CW-1:0] w_idx_dec;
    logic [IW-1:0] w_res_pos;
    logic [31:0]   w_pos_ext;
    logic [31:0]   w_cnt_ext;

    assign w_full       = (r_count == CW'(TABLE_DEPTH));
    assign w_insert_adv = (r_op == stid_pkg::CMD_INSERT) && !r_found
                          && ($signed(r_rd_data) < r_value);
    assign w_idx_dec    = r_idx - CW'(1);

    assign o_status.is_insert = (r_op == stid_pkg::CMD_INSERT);
    assign o_status.full      = w_full;
    assign o_status.at_end    = (r_idx == r_count);
    assign o_out              = r_out;

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_idx[IW-1:0];
        w_data = r_carry;
        if (i_cmd.cmp) begin
            if (r_op == stid_pkg::CMD_INSERT) begin
                w_en = !w_insert_adv;
            end else if (r_found) begin
                w_en   = 1'b1;
                w_addr = w_idx_dec[IW-1:0];
                w_data = r_rd_data;
            end
        end else if (i_cmd.fin) begin
            w_en = (r_op == stid_pkg::CMD_INSERT) && !w_full;
        end
    end

    always_comb begin
        n_count   = r_count;
        w_res_pos = '0;
        n_out.status = stid_pkg::ST_DONE;
        if (r_op == stid_pkg::CMD_INSERT) begin
            if (w_full) begin
                n_out.status = stid_pkg::ST_FULL;
            end else begin
                n_count   = r_count + CW'(1);
                w_res_pos = r_found ? r_pos : r_idx[IW-1:0];
            end
        end else begin
            if (r_found) begin
                n_count   = r_count - CW'(1);
                w_res_pos = r_pos;
            end else begin
                n_out.status = stid_pkg::ST_NOT_FOUND;
            end
        end
        w_pos_ext         = 32'(w_res_pos);
        w_cnt_ext         = 32'(n_count);
        n_out.position    = w_pos_ext[3:0];
        n_out.entry_count = w_cnt_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.fin) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in.cmd;
            r_value <= i_in.value;
            r_carry <= i_in.value;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else if (i_cmd.cmp) begin
            r_idx <= r_idx + CW'(1);
            if (r_op == stid_pkg::CMD_INSERT) begin
                if (!w_insert_adv) begin
                    r_carry <= r_rd_data;
                    if (!r_found) begin
                        r_found <= 1'b1;
                        r_pos   <= r_idx[IW-1:0];
                    end
                end
            end else if (!r_found && (r_rd_data == r_value)) begin
                r_found <= 1'b1;
                r_pos   <= r_idx[IW-1:0];
            end
        end
        if (i_cmd.fin) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- src/stid_controller.sv -----
// Controller of the sorted table core: sequences the scan and owns both handshakes.
// Depends on stid_pkg; drives stid_datapath.
module stid_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    input  stid_pkg::t_dp_status  i_status,
    output stid_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_stop;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_stop     = (i_status.is_insert && i_status.full) || i_status.at_end;
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        o_cmd.rd   = (r_state == S_RD) && !w_stop;
        o_cmd.cmp  = (r_state == S_CMP);
        o_cmd.fin  = (r_state == S_FIN) && w_out_free;

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = w_stop ? S_FIN : S_CMP;
            end
            S_CMP: begin
                n_state = S_RD;
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- src/sorted_table_insert_delete_core.sv -----
// Sorted table core: one command at a time; a scan reads each entry, then compares it.
// A command is scanned over every stored entry before its finish state registers the result;
// a refused insert skips the scan. The next command can be accepted from the cycle the result turns valid.
// A command is accepted while the previous result waits; its last cycle holds until that is taken.
// Synchronous active-low reset empties the table at once; entry memory is not cleared.
// Depends on stid_pkg, stid_controller, stid_datapath and the defines header.
`include "sorted_table_insert_delete_core_defines.svh"

module sorted_table_insert_delete_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  stid_pkg::t_in_item   i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output stid_pkg::t_out_item  o_out
);

    stid_pkg::t_dp_cmd    w_cmd;
    stid_pkg::t_dp_status w_status;
    logic                 w_res_full;
    logic                 w_res_failed;

    stid_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    stid_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_in     (i_in),
        .o_status (w_status),
        .o_out    (o_out)
    );

    assign w_res_full   = o_valid && (o_out.status == stid_pkg::ST_FULL);
    assign w_res_failed = o_valid && (o_out.status != stid_pkg::ST_DONE);

    `STID_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `STID_ASSERT_IMP(a_full_reports_depth, w_res_full, o_out.entry_count == 5'(TABLE_DEPTH))
    `STID_ASSERT_IMP(a_fail_zero_position, w_res_failed, o_out.position == 4'd0)

endmodule
